/* hdl/alu64_pkg.sv */
// Package for the 64-bit arithmetic unit.
// Holds widths, command codes, state encoding and controller-to-datapath command type.
// No dependencies.
`default_nettype none

package alu64_pkg;

    localparam int unsigned DATA_W   = 64;
    localparam int unsigned CMD_W    = 3;
    localparam int unsigned ORDER_W  = 2;
    localparam int unsigned IN_W     = 2 * DATA_W;
    localparam int unsigned OUT_RAW  = DATA_W + 1 + ORDER_W;
    localparam int unsigned OUT_W    = ((OUT_RAW + 7) / 8) * 8;
    localparam int unsigned STEP_W   = $clog2(DATA_W);

    localparam logic [ORDER_W-1:0] ORDER_EQ = 2'b00;
    localparam logic [ORDER_W-1:0] ORDER_GT = 2'b01;
    localparam logic [ORDER_W-1:0] ORDER_LT = 2'b11;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD = 3'd0,
        CMD_SUB = 3'd1,
        CMD_NEG = 3'd2,
        CMD_CMP = 3'd3,
        CMD_SHR = 3'd4,
        CMD_MUL = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load_alu;
        logic load_mul;
        logic step;
        logic load_mul_out;
    } t_dp_cmd;

endpackage

`default_nettype wire

/* hdl/alu64_dp.sv */
// Datapath of the 64-bit arithmetic unit: single-pass operations, shift-add multiplier
// registers and the output register. Depends on alu64_pkg.
`default_nettype none

module alu64_dp (
    input  wire logic                          i_clk,
    input  wire alu64_pkg::t_dp_cmd            i_cmd,
    input  wire logic [alu64_pkg::CMD_W-1:0]   i_op,
    input  wire logic [alu64_pkg::DATA_W-1:0]  i_a,
    input  wire logic [alu64_pkg::DATA_W-1:0]  i_b,
    output logic      [alu64_pkg::OUT_W-1:0]   o_tdata
);

    logic [alu64_pkg::DATA_W-1:0]   r_mcand;
    logic [alu64_pkg::DATA_W-1:0]   r_hi;
    logic [alu64_pkg::DATA_W-1:0]   r_lo;
    logic [alu64_pkg::DATA_W-1:0]   r_value;
    logic                           r_flag;
    logic [alu64_pkg::ORDER_W-1:0]  r_order;

    logic [alu64_pkg::DATA_W:0]     add_sum;
    logic [alu64_pkg::DATA_W:0]     sub_dif;
    logic [alu64_pkg::DATA_W:0]     step_sum;
    logic [alu64_pkg::DATA_W-1:0]   n_value;
    logic                           n_flag;
    logic [alu64_pkg::ORDER_W-1:0]  n_order;

    assign add_sum  = {1'b0, i_a} + {1'b0, i_b};
    assign sub_dif  = {1'b0, i_a} - {1'b0, i_b};
    assign step_sum = {1'b0, r_hi}
                    + (r_lo[0] ? {1'b0, r_mcand} : {(alu64_pkg::DATA_W + 1){1'b0}});

    always_comb begin
        n_value = '0;
        n_flag  = 1'b0;
        n_order = alu64_pkg::ORDER_EQ;
        case (alu64_pkg::t_cmd'(i_op))
            alu64_pkg::CMD_ADD: begin
                n_value = add_sum[alu64_pkg::DATA_W-1:0];
                n_flag  = add_sum[alu64_pkg::DATA_W];
            end
            alu64_pkg::CMD_SUB: begin
                n_value = sub_dif[alu64_pkg::DATA_W-1:0];
                n_flag  = sub_dif[alu64_pkg::DATA_W];
            end
            alu64_pkg::CMD_NEG: begin
                n_value = (~i_a) + {{(alu64_pkg::DATA_W - 1){1'b0}}, 1'b1};
            end
            alu64_pkg::CMD_CMP: begin
                if (i_a > i_b) begin
                    n_order = alu64_pkg::ORDER_GT;
                end else if (i_a < i_b) begin
                    n_order = alu64_pkg::ORDER_LT;
                end
            end
            alu64_pkg::CMD_SHR: begin
                n_value = {1'b0, i_a[alu64_pkg::DATA_W-1:1]};
            end
            default: begin
                n_value = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_mul) begin
            r_mcand <= i_a;
            r_hi    <= '0;
            r_lo    <= i_b;
        end else if (i_cmd.step) begin
            r_hi <= step_sum[alu64_pkg::DATA_W:1];
            r_lo <= {step_sum[0], r_lo[alu64_pkg::DATA_W-1:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_alu) begin
            r_value <= n_value;
            r_flag  <= n_flag;
            r_order <= n_order;
        end else if (i_cmd.load_mul_out) begin
            r_value <= r_lo;
            r_flag  <= (r_hi != '0);
            r_order <= alu64_pkg::ORDER_EQ;
        end
    end

    assign o_tdata = {{(alu64_pkg::OUT_W - alu64_pkg::OUT_RAW){1'b0}},
                      r_order, r_flag, r_value};

endmodule

`default_nettype wire

/* hdl/alu64_ctrl.sv */
// Controller of the 64-bit arithmetic unit: handshakes, multiply step counter, output valid.
// Depends on alu64_pkg.
`default_nettype none

module alu64_ctrl (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic [alu64_pkg::CMD_W-1:0]  i_op,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output alu64_pkg::t_dp_cmd                o_dp_cmd
);

    alu64_pkg::t_state                r_state;
    alu64_pkg::t_state                n_state;
    logic [alu64_pkg::STEP_W-1:0]     r_cnt;
    logic [alu64_pkg::STEP_W-1:0]     n_cnt;
    logic                             r_out_valid;
    logic                             n_out_valid;
    logic                             out_free;
    logic                             accept;
    logic                             is_mul;
    logic                             last_step;

    assign out_free  = !r_out_valid || i_out_ready;
    assign is_mul    = (i_op == alu64_pkg::CMD_MUL);
    assign last_step = (r_cnt == {alu64_pkg::STEP_W{1'b1}});
    assign accept    = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            alu64_pkg::ST_IDLE: begin
                if (accept && is_mul) begin
                    n_state = alu64_pkg::ST_MUL;
                end
            end
            alu64_pkg::ST_MUL: begin
                if (last_step) begin
                    n_state = alu64_pkg::ST_DONE;
                end
            end
            alu64_pkg::ST_DONE: begin
                if (out_free) begin
                    n_state = alu64_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = alu64_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_dp_cmd   = '0;
        case (r_state)
            alu64_pkg::ST_IDLE: begin
                o_in_ready        = out_free;
                o_dp_cmd.load_alu = i_in_valid && out_free && !is_mul;
                o_dp_cmd.load_mul = i_in_valid && out_free && is_mul;
            end
            alu64_pkg::ST_MUL: begin
                o_dp_cmd.step = 1'b1;
            end
            alu64_pkg::ST_DONE: begin
                o_dp_cmd.load_mul_out = out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_cnt = r_cnt;
        if (o_dp_cmd.load_mul) begin
            n_cnt = '0;
        end else if (o_dp_cmd.step) begin
            n_cnt = r_cnt + 1'b1;
        end
        n_out_valid = r_out_valid && !i_out_ready;
        if (o_dp_cmd.load_alu || o_dp_cmd.load_mul_out) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= alu64_pkg::ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

`ifndef SYNTH
    a_mul_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && is_mul) |=> (r_state == alu64_pkg::ST_MUL && r_cnt == '0))
        else $error("multiply did not start with a cleared step count");

    a_mul_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == alu64_pkg::ST_MUL && last_step) |=> (r_state == alu64_pkg::ST_DONE))
        else $error("multiply did not finish after the last step");

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (r_state == alu64_pkg::ST_IDLE))
        else $error("input ready outside idle");

    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_dp_cmd.load_alu || o_dp_cmd.load_mul_out) |=> r_out_valid)
        else $error("output loaded without valid");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !(o_dp_cmd.load_alu || o_dp_cmd.load_mul_out))
        else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire

/* hdl/alu_64bit_add_sub_mul_cmp_unit.sv */
// Top level of the 64-bit unsigned arithmetic unit: controller plus datapath.
// Depends on alu64_pkg, alu64_ctrl and alu64_dp.
//
// Channel   Dir  Fields (tdata from bit 0 up)                 tuser
// s_axis    in   operand_a[63:0], operand_b[127:64]            command[2:0]
// m_axis    out  value[63:0], carry_flag[64], order[66:65]     -
//
// Add, subtract, negate, compare and shift are computed combinationally and registered on acceptance.
// Multiply runs 64 shift-add steps on one 64-bit adder, then loads the product into the output register.
// A new transaction is taken once the unit is idle and the output register is free or draining.
// Reset is synchronous, active low, and clears the controller and the output valid.
// A stalled output holds its result; the input stalls until it can be written.
`default_nettype none

module alu_64bit_add_sub_mul_cmp_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // operand_a, operand_b
    input  wire logic [alu64_pkg::IN_W-1:0]    s_axis_tdata,
    // command
    input  wire logic [alu64_pkg::CMD_W-1:0]   s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // value, carry_flag, order, zero padding
    output logic      [alu64_pkg::OUT_W-1:0]   m_axis_tdata
);

    alu64_pkg::t_dp_cmd dp_cmd;

    alu64_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_op        (s_axis_tuser),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_dp_cmd    (dp_cmd)
    );

    alu64_dp u_dp (
        .i_clk   (i_clk),
        .i_cmd   (dp_cmd),
        .i_op    (s_axis_tuser),
        .i_a     (s_axis_tdata[alu64_pkg::DATA_W-1:0]),
        .i_b     (s_axis_tdata[alu64_pkg::IN_W-1:alu64_pkg::DATA_W]),
        .o_tdata (m_axis_tdata)
    );

endmodule

`default_nettype wire
